FILE: design/orcv_pkg.sv
package orcv_pkg;

    // command from controller to datapath
    typedef struct packed {
        logic load_ramp;    // first item: load scale/offset directly
        logic win_rd;       // latch the new window bit, reload pulse on onset
        logic pos_red;      // one compare/subtract step of the position reduction
        logic win_upd;      // update count, store bit, advance position
        logic leak_upd;     // leaky level multiply, saturate, store
        logic mix_a;        // (1-m)*count
        logic mix_b;        // m*leaky, sum, saturate
        logic smooth_a;     // a*target
        logic smooth_b;     // (1-a)*smoothed, sum
        logic ramp_s;       // scale ramp
        logic ramp_o;       // offset ramp
        logic out_mul;      // smoothed*scale
        logic out_fin;      // clamp, invert, pulse, present result
    } dp_cmd_t;

    localparam logic [16:0] ONE_Q16   = 17'd65536;
    localparam logic [23:0] LEAKY_MAX = 24'hFFFFFF;
    localparam logic [27:0] LEVEL_MAX = 28'hFFFFFFF;

    localparam logic [2:0] REG_WIN_SIZE      = 3'd0;
    localparam logic [2:0] REG_LEAK_FACTOR   = 3'd1;
    localparam logic [2:0] REG_MIX_FRACTION  = 3'd2;
    localparam logic [2:0] REG_SMOOTH_ALPHA  = 3'd3;
    localparam logic [2:0] REG_SCALE_SET     = 3'd4;
    localparam logic [2:0] REG_OFFSET_SET    = 3'd5;
    localparam logic [2:0] REG_INVERT_OUTPUT = 3'd6;
    localparam logic [2:0] REG_PULSE_LENGTH  = 3'd7;

endpackage

FILE: design/orcv_ram.sv
module orcv_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: design/orcv_ctrl.sv
module orcv_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_action,
    output logic               in_ready,
    output logic               clear_busy,
    input  logic               clear_done,
    input  logic               res_free,
    input  logic               pos_ok,
    output orcv_pkg::dp_cmd_t  cmd
);

    localparam logic [3:0] S_CLEAR  = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_H_RD   = 4'd2;
    localparam logic [3:0] S_H_UPD  = 4'd3;
    localparam logic [3:0] S_H_MIXA = 4'd5;
    localparam logic [3:0] S_H_MIXB = 4'd6;
    localparam logic [3:0] S_T_SMA  = 4'd7;
    localparam logic [3:0] S_T_SMB  = 4'd8;
    localparam logic [3:0] S_T_RS   = 4'd9;
    localparam logic [3:0] S_T_RO   = 4'd10;
    localparam logic [3:0] S_T_MUL  = 4'd11;
    localparam logic [3:0] S_T_FIN  = 4'd12;
    localparam logic [3:0] S_H_LUPD = 4'd13;

    logic [3:0] state_reg, state_next;
    logic       loaded_reg, loaded_next;
    logic       take;

    // accept only when idle
    assign in_ready   = (state_reg == S_IDLE);
    assign take       = in_valid && in_ready;
    assign clear_busy = (state_reg == S_CLEAR);

    always_comb
    begin
        state_next  = state_reg;
        loaded_next = loaded_reg;
        cmd         = '0;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (clear_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (take)
                begin
                    cmd.load_ramp = !loaded_reg;
                    loaded_next   = 1'b1;
                    cmd.win_rd    = in_action;
                    if (in_action)
                        state_next = pos_ok ? S_H_UPD : S_H_RD;
                    else
                        state_next = S_T_SMA;
                end
            end
            // reduce the position into the window, then read the cell
            S_H_RD:
            begin
                if (pos_ok)
                    state_next = S_H_UPD;
                else
                    cmd.pos_red = 1'b1;
            end
            S_H_UPD:
            begin
                cmd.win_upd = 1'b1;
                state_next  = S_H_LUPD;
            end
            S_H_LUPD:
            begin
                cmd.leak_upd = 1'b1;
                state_next   = S_H_MIXA;
            end
            S_H_MIXA:
            begin
                cmd.mix_a  = 1'b1;
                state_next = S_H_MIXB;
            end
            S_H_MIXB:
            begin
                cmd.mix_b  = 1'b1;
                state_next = S_IDLE;
            end
            S_T_SMA:
            begin
                cmd.smooth_a = 1'b1;
                state_next   = S_T_SMB;
            end
            S_T_SMB:
            begin
                cmd.smooth_b = 1'b1;
                state_next   = S_T_RS;
            end
            S_T_RS:
            begin
                cmd.ramp_s = 1'b1;
                state_next = S_T_RO;
            end
            S_T_RO:
            begin
                cmd.ramp_o = 1'b1;
                state_next = S_T_MUL;
            end
            S_T_MUL:
            begin
                cmd.out_mul = 1'b1;
                state_next  = S_T_FIN;
            end
            // hold until the output register can take the word
            S_T_FIN:
            begin
                if (res_free)
                begin
                    cmd.out_fin = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_CLEAR;
            loaded_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            loaded_reg <= loaded_next;
        end
    end

endmodule

FILE: design/orcv_dp.sv
module orcv_dp #(
    parameter int WINDOW_DEPTH = 2048,
    parameter int RAMP_ALPHA   = 136
) (
    input  logic               clk,
    input  logic               rst_n,
    input  orcv_pkg::dp_cmd_t  cmd,
    input  logic               in_onset,
    input  logic               in_silent,
    input  logic               clear_busy,
    output logic               clear_done,
    input  logic [11:0]        win_size,
    input  logic [15:0]        leak_factor,
    input  logic [16:0]        mix_fraction,
    input  logic [16:0]        smooth_alpha,
    input  logic signed [15:0] scale_set,
    input  logic signed [15:0] offset_set,
    input  logic               invert_output,
    input  logic [15:0]        pulse_length,
    output logic               pos_ok,
    output logic               res_pending,
    output logic               res_free,
    input  logic               out_ready,
    output logic [16:0]        control_value,
    output logic               trigger_high
);

    localparam int AW = $clog2(WINDOW_DEPTH);
    localparam int CW = AW + 1;
    localparam int KW = $clog2(AW);

    logic [AW-1:0] pos_reg, clr_addr_reg;
    logic [CW-1:0] count_reg;
    logic [23:0]   leaky_reg;
    logic [27:0]   target_reg, smoothed_reg;
    logic signed [23:0] scale_reg, offset_reg;
    logic [15:0]   pulse_reg;
    logic          cur_reg;
    logic [47:0]   acc_reg;
    logic signed [52:0] prod_reg;
    logic [16:0]   cv_reg;
    logic          trig_reg, pend_reg;
    logic [KW-1:0] red_k_reg;

    // effective window size; position is reduced before use
    logic [CW-1:0]    cells;
    logic [AW-1:0]    slot;
    logic [CW+AW-1:0] red_sub;
    always_comb
    begin
        if (win_size == 12'd0)
            cells = CW'(1);
        else if (32'(win_size) > WINDOW_DEPTH)
            cells = CW'(WINDOW_DEPTH);
        else
            cells = CW'(win_size);
        slot    = pos_reg;
        red_sub = (CW+AW)'(cells) << red_k_reg;
    end

    assign pos_ok = ({1'b0, pos_reg} < cells);

    // window store: cleared once after reset
    logic          ram_we, old_bit;
    logic [AW-1:0] ram_waddr;
    assign ram_we    = clear_busy || cmd.win_upd;
    assign ram_waddr = clear_busy ? clr_addr_reg : slot;
    assign clear_done = clear_busy && (clr_addr_reg == AW'(WINDOW_DEPTH - 1));

    orcv_ram #(.WIDTH(1), .DEPTH(WINDOW_DEPTH)) u_win (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (clear_busy ? 1'b0 : cur_reg),
        .raddr (slot),
        .rdata (old_bit)
    );

    // arithmetic helpers
    logic [16:0] m_eff, a_eff;
    assign m_eff = (mix_fraction > orcv_pkg::ONE_Q16) ? orcv_pkg::ONE_Q16 : mix_fraction;
    assign a_eff = (smooth_alpha == 17'd0) ? 17'd1 :
                   (smooth_alpha > orcv_pkg::ONE_Q16) ? orcv_pkg::ONE_Q16 : smooth_alpha;

    logic [47:0] mix_sum, sm_sum;
    logic [40:0] leak_prod;
    logic [31:0] leak_sum;
    logic signed [41:0] ramp_prod, rdiff;
    logic signed [24:0] ramp_in;
    logic signed [24:0] tgt;
    logic signed [36:0] pshift;
    logic signed [37:0] vsum;
    logic [16:0] clamped;

    always_comb
    begin
        leak_prod = 41'(leak_factor * leaky_reg) >> 16;
        leak_sum  = 32'(leak_prod) + (cur_reg ? 32'd65536 : 32'd0);
        mix_sum   = acc_reg + 48'(m_eff * leaky_reg);
        sm_sum    = acc_reg + 48'((orcv_pkg::ONE_Q16 - a_eff) * smoothed_reg);
        ramp_in   = cmd.ramp_s ? 25'(scale_reg) : 25'(offset_reg);
        tgt       = cmd.ramp_s ? 25'($signed({scale_set, 8'd0}))
                               : 25'($signed({offset_set, 8'd0}));
        rdiff     = 42'(tgt - ramp_in);
        ramp_prod = 42'(rdiff * $signed(42'(RAMP_ALPHA))) + 42'sd32768;
        pshift    = 37'(prod_reg >>> 16);
        vsum      = 38'(pshift) + 38'(offset_reg);
        if (vsum < 0)
            clamped = 17'd0;
        else if (vsum > 38'sd65536)
            clamped = orcv_pkg::ONE_Q16;
        else
            clamped = 17'(vsum);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0; clr_addr_reg <= '0; count_reg <= '0;
            leaky_reg <= '0; target_reg <= '0; smoothed_reg <= '0;
            scale_reg <= '0; offset_reg <= '0; pulse_reg <= '0;
            cur_reg <= 1'b0; pend_reg <= 1'b0;
            red_k_reg <= KW'(AW - 1);
        end
        else
        begin
            if (clear_busy)
                clr_addr_reg <= clr_addr_reg + AW'(1);
            if (cmd.out_fin)
                pend_reg <= 1'b1;
            else if (pend_reg && out_ready)
                pend_reg <= 1'b0;
            if (cmd.load_ramp)
            begin
                scale_reg  <= 24'($signed({scale_set, 8'd0}));
                offset_reg <= 24'($signed({offset_set, 8'd0}));
            end
            if (cmd.win_rd)
            begin
                cur_reg <= in_onset && !in_silent;
                if (in_onset && !in_silent)
                    pulse_reg <= pulse_length;
            end
            // restoring remainder: subtract cells << k, k counting down
            if (cmd.pos_red)
            begin
                if ((CW+AW)'(pos_reg) >= red_sub)
                    pos_reg <= AW'((CW+AW)'(pos_reg) - red_sub);
                red_k_reg <= red_k_reg - KW'(1);
            end
            else
                red_k_reg <= KW'(AW - 1);
            if (cmd.win_upd)
            begin
                count_reg <= count_reg - CW'(old_bit) + CW'(cur_reg);
                pos_reg   <= ({1'b0, slot} + CW'(1) >= cells) ? '0 : slot + AW'(1);
            end
            if (cmd.leak_upd)
                leaky_reg <= (leak_sum > 32'(orcv_pkg::LEAKY_MAX)) ?
                             orcv_pkg::LEAKY_MAX : leak_sum[23:0];
            if (cmd.mix_a)
                acc_reg <= 48'((orcv_pkg::ONE_Q16 - m_eff) * {count_reg, 16'd0});
            if (cmd.mix_b)
                target_reg <= ((mix_sum >> 16) > 48'(orcv_pkg::LEVEL_MAX)) ?
                              orcv_pkg::LEVEL_MAX : mix_sum[43:16];
            if (cmd.smooth_a)
                acc_reg <= 48'(a_eff * target_reg);
            if (cmd.smooth_b)
                smoothed_reg <= sm_sum[43:16];
            if (cmd.ramp_s)
                scale_reg <= 24'(ramp_in + 25'(ramp_prod >>> 16));
            if (cmd.ramp_o)
                offset_reg <= 24'(ramp_in + 25'(ramp_prod >>> 16));
            if (cmd.out_mul)
                prod_reg <= 53'($signed({1'b0, smoothed_reg}) * scale_reg);
            if (cmd.out_fin)
            begin
                cv_reg   <= invert_output ? orcv_pkg::ONE_Q16 - clamped : clamped;
                trig_reg <= (pulse_reg != 16'd0);
                if (pulse_reg != 16'd0)
                    pulse_reg <= pulse_reg - 16'd1;
            end
        end
    end

    assign res_pending   = pend_reg;
    assign res_free      = !pend_reg || out_ready;
    assign control_value = cv_reg;
    assign trigger_high  = trig_reg;

endmodule

FILE: design/onset_rate_cv_generator.sv
// channel  | dir | tdata (low bit up)             | tuser
// s_axis   | in  | onset_flag, silent_flag        | action
// m_axis   | out | control_value[16:0], trigger  | -
// cfg      | in  | cfg_we, cfg_addr, cfg_data (17 bits)
// A hop updates window cell and count, the leaky level, then mixes; a position
// past a shrunken window is first reduced. A tick smooths, ramps, multiplies.
// After reset all WINDOW_DEPTH window cells are cleared; no input is taken.
// A finished result waits in the output register; the next item is still
// taken, and a tick holds in its last step until that register frees.
module onset_rate_cv_generator #(
    parameter int WINDOW_DEPTH = 2048,
    parameter int RAMP_ALPHA   = 136
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // onset_flag, silent_flag
    input  logic        s_axis_tuser,   // action
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // control_value[16:0], trigger_high
    input  logic        cfg_we,
    input  logic [2:0]  cfg_addr,
    input  logic [16:0] cfg_data
);

    logic [11:0] win_size_reg;
    logic [15:0] leak_factor_reg, pulse_length_reg;
    logic [16:0] mix_fraction_reg, smooth_alpha_reg;
    logic signed [15:0] scale_set_reg, offset_set_reg;
    logic invert_output_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_size_reg      <= 12'd1;
            leak_factor_reg   <= '0;
            mix_fraction_reg  <= '0;
            smooth_alpha_reg  <= 17'd65536;
            scale_set_reg     <= 16'sd256;
            offset_set_reg    <= '0;
            invert_output_reg <= 1'b0;
            pulse_length_reg  <= 16'd480;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                orcv_pkg::REG_WIN_SIZE:      win_size_reg      <= cfg_data[11:0];
                orcv_pkg::REG_LEAK_FACTOR:   leak_factor_reg   <= cfg_data[15:0];
                orcv_pkg::REG_MIX_FRACTION:  mix_fraction_reg  <= cfg_data;
                orcv_pkg::REG_SMOOTH_ALPHA:  smooth_alpha_reg  <= cfg_data;
                orcv_pkg::REG_SCALE_SET:     scale_set_reg     <= cfg_data[15:0];
                orcv_pkg::REG_OFFSET_SET:    offset_set_reg    <= cfg_data[15:0];
                orcv_pkg::REG_INVERT_OUTPUT: invert_output_reg <= cfg_data[0];
                orcv_pkg::REG_PULSE_LENGTH:  pulse_length_reg  <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    orcv_pkg::dp_cmd_t cmd;
    logic clear_busy, clear_done, res_pending, res_free, pos_ok, trig;
    logic [16:0] cv;

    orcv_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_axis_tvalid),
        .in_action   (s_axis_tuser),
        .in_ready    (s_axis_tready),
        .clear_busy  (clear_busy),
        .clear_done  (clear_done),
        .res_free    (res_free),
        .pos_ok      (pos_ok),
        .cmd         (cmd)
    );

    orcv_dp #(.WINDOW_DEPTH(WINDOW_DEPTH), .RAMP_ALPHA(RAMP_ALPHA)) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .in_onset      (s_axis_tdata[0]),
        .in_silent     (s_axis_tdata[1]),
        .clear_busy    (clear_busy),
        .clear_done    (clear_done),
        .win_size      (win_size_reg),
        .leak_factor   (leak_factor_reg),
        .mix_fraction  (mix_fraction_reg),
        .smooth_alpha  (smooth_alpha_reg),
        .scale_set     (scale_set_reg),
        .offset_set    (offset_set_reg),
        .invert_output (invert_output_reg),
        .pulse_length  (pulse_length_reg),
        .pos_ok        (pos_ok),
        .res_pending   (res_pending),
        .res_free      (res_free),
        .out_ready     (m_axis_tready),
        .control_value (cv),
        .trigger_high  (trig)
    );

    assign m_axis_tvalid = res_pending;
    assign m_axis_tdata  = {6'd0, trig, cv};

endmodule
